// File: sv/amat_pkg.sv
// ----------------------------------------------------------------------------
// amat_pkg: shared types and constants
// Field widths, direction codes and the result bundle passed from the window
// unit to the output stage.
// ----------------------------------------------------------------------------
package amat_pkg;

  // field widths
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned TOTAL_W = 21;
  localparam int unsigned THR_W   = 16;

  // sum of three squares of 16-bit signed values fits in 32 bits
  localparam int unsigned ACC_W   = 32;

  // largest magnitude that can occur
  localparam int unsigned MAG_MAX = 56755;

  // threshold after reset
  localparam logic [THR_W-1:0] THR_RESET = 16'd1100;

  // comparison outcome of window mean against threshold
  typedef enum logic [1:0] {
    DIR_EQUAL = 2'd0,
    DIR_UP    = 2'd1,
    DIR_DOWN  = 2'd2
  } dir_e;

  typedef struct packed {
    logic [MAG_W-1:0]   magnitude;
    logic [TOTAL_W-1:0] window_total;
    dir_e               direction;
  } result_t;

endpackage

// File: sv/amat_sqrt.sv
// ----------------------------------------------------------------------------
// amat_sqrt: squared magnitude and floor square root
// Squares the three axes one after another on one shared multiplier, then
// extracts the 16-bit floor root one bit per cycle.
// ----------------------------------------------------------------------------
module amat_sqrt (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [amat_pkg::AXIS_W-1:0]    x_i,
  input  logic signed [amat_pkg::AXIS_W-1:0]    y_i,
  input  logic signed [amat_pkg::AXIS_W-1:0]    z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic        [amat_pkg::MAG_W-1:0]     mag_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SQ   = 2'd1;
  localparam logic [1:0] S_ROOT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam int unsigned REM_W  = amat_pkg::MAG_W + 1;
  localparam int unsigned IT_W   = $clog2(amat_pkg::MAG_W);
  localparam logic [1:0]  SQ_LAST = 2'd2;
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(amat_pkg::MAG_W - 1);

  logic [1:0] state_q, state_d;
  logic [1:0] sqcnt_q, sqcnt_d;
  logic [IT_W-1:0] itcnt_q, itcnt_d;

  logic signed [amat_pkg::AXIS_W-1:0] ax_q, ay_q, az_q;
  logic [amat_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [REM_W-1:0]           rem_q, rem_d;
  logic [amat_pkg::MAG_W-1:0] root_q, root_d;

  logic signed [amat_pkg::ACC_W-1:0] ax_wide;
  logic signed [amat_pkg::ACC_W-1:0] sq;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] rem_sub;
  logic             ge;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign mag_o       = root_q;

  // one square per cycle
  assign ax_wide = amat_pkg::ACC_W'(ax_q);
  assign sq      = ax_wide * ax_wide;

  // one root bit: bring down two radicand bits and try root*4+1
  assign rem_sh  = {rem_q, acc_q[amat_pkg::ACC_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  // sequencer
  always_comb begin
    state_d = state_q;
    sqcnt_d = sqcnt_q;
    itcnt_d = itcnt_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    root_d  = root_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SQ;
          sqcnt_d = '0;
          acc_d   = '0;
        end
      end
      S_SQ: begin
        acc_d   = acc_q + amat_pkg::ACC_W'(unsigned'(sq));
        sqcnt_d = sqcnt_q + 2'd1;
        if (sqcnt_q == SQ_LAST) begin
          state_d = S_ROOT;
          itcnt_d = '0;
          rem_d   = '0;
          root_d  = '0;
        end
      end
      S_ROOT: begin
        acc_d   = {acc_q[amat_pkg::ACC_W-3:0], 2'b00};
        rem_d   = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_d  = {root_q[amat_pkg::MAG_W-2:0], ge};
        itcnt_d = itcnt_q + IT_W'(1);
        if (itcnt_q == IT_LAST) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sqcnt_q <= '0;
      itcnt_q <= '0;
    end else begin
      state_q <= state_d;
      sqcnt_q <= sqcnt_d;
      itcnt_q <= itcnt_d;
    end
  end

  // datapath, axis operands shift toward the multiplier
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    if (state_q == S_IDLE && in_valid_i) begin
      ax_q <= x_i;
      ay_q <= y_i;
      az_q <= z_i;
    end else if (state_q == S_SQ) begin
      ax_q <= ay_q;
      ay_q <= az_q;
    end
  end

endmodule

// File: sv/amat_window.sv
// ----------------------------------------------------------------------------
// amat_window: magnitude window and threshold compare
// Keeps the last WINDOW magnitudes in a synchronous memory, updates the
// running sum by read-modify-write and compares it with threshold * WINDOW.
// ----------------------------------------------------------------------------
module amat_window #(
  parameter int unsigned WINDOW = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [amat_pkg::THR_W-1:0]    thr_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [amat_pkg::MAG_W-1:0]    mag_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output amat_pkg::result_t             res_o
);

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned TOT_W  = $clog2(WINDOW * amat_pkg::MAG_MAX + 1);
  localparam int unsigned LIM_W  = amat_pkg::THR_W + $clog2(WINDOW + 1);
  localparam int unsigned CMP_W  = (TOT_W > LIM_W) ? TOT_W : LIM_W;
  localparam int unsigned EXT_W  = TOT_W + amat_pkg::TOTAL_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [LIM_W-1:0]  WIN_K     = LIM_W'(WINDOW);

  localparam logic [1:0] W_IDLE = 2'd0;
  localparam logic [1:0] W_UPD  = 2'd1;
  localparam logic [1:0] W_CMP  = 2'd2;
  localparam logic [1:0] W_DONE = 2'd3;

  logic [1:0]                 state_q, state_d;
  logic [SLOT_W-1:0]          slot_q;
  logic                       full_q;
  logic [TOT_W-1:0]           total_q;
  logic [amat_pkg::MAG_W-1:0] mag_q;
  logic [LIM_W-1:0]           limit_q;
  amat_pkg::dir_e             dir_q;

  logic [amat_pkg::MAG_W-1:0] mem [WINDOW];
  logic [amat_pkg::MAG_W-1:0] rdata_q;
  logic [amat_pkg::MAG_W-1:0] old_mag;
  logic [TOT_W-1:0]           total_upd;
  logic [CMP_W-1:0]           tot_cmp, lim_cmp;
  logic [EXT_W-1:0]           tot_ext;
  logic                       upd;

  assign in_ready_o  = (state_q == W_IDLE);
  assign out_valid_o = (state_q == W_DONE);
  assign upd         = (state_q == W_UPD);

  // entries not yet written since reset read as zero
  assign old_mag   = full_q ? rdata_q : '0;
  assign total_upd = total_q - TOT_W'(old_mag) + TOT_W'(mag_q);

  assign tot_cmp = CMP_W'(total_q);
  assign lim_cmp = CMP_W'(limit_q);
  assign tot_ext = EXT_W'(total_q);

  assign res_o.magnitude    = mag_q;
  assign res_o.window_total = tot_ext[amat_pkg::TOTAL_W-1:0];
  assign res_o.direction    = dir_q;

  // window memory, the read of the oldest entry is registered and lands in the cycle after the slot
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[slot_q];
    if (upd) begin
      mem[slot_q] <= mag_q;
    end
  end

  // stage sequencing
  always_comb begin
    state_d = state_q;
    case (state_q)
      W_IDLE: if (in_valid_i) state_d = W_UPD;
      W_UPD:  state_d = W_CMP;
      W_CMP:  state_d = W_DONE;
      W_DONE: if (out_ready_i) state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      slot_q  <= '0;
      full_q  <= 1'b0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      if (upd) begin
        total_q <= total_upd;
        if (slot_q == SLOT_LAST) begin
          slot_q <= '0;
          full_q <= 1'b1;
        end else begin
          slot_q <= slot_q + SLOT_W'(1);
        end
      end
    end
  end

  // payload: magnitude, limit, then direction
  always_ff @(posedge clk_i) begin
    if (state_q == W_IDLE && in_valid_i) begin
      mag_q <= mag_i;
    end
    if (upd) begin
      limit_q <= LIM_W'(thr_i) * WIN_K;
    end
    if (state_q == W_CMP) begin
      if (tot_cmp > lim_cmp) begin
        dir_q <= amat_pkg::DIR_UP;
      end else if (tot_cmp < lim_cmp) begin
        dir_q <= amat_pkg::DIR_DOWN;
      end else begin
        dir_q <= amat_pkg::DIR_EQUAL;
      end
    end
  end

endmodule

// File: sv/accel_magnitude_average_threshold.sv
// ----------------------------------------------------------------------------
// accel_magnitude_average_threshold: accelerometer magnitude level detector
// Floor root of x^2+y^2+z^2, moving window sum and threshold direction.
// ----------------------------------------------------------------------------
// Each input word is one three-axis sample; each sample gives exactly one
// output word with its magnitude, the sum of the last WINDOW magnitudes and
// whether the window mean lies above, below or at the threshold. The root unit
// takes a new sample only after handing on the last magnitude: it squares the
// three axes on one multiplier, extracts the 16 root bits one at a time, then
// hands off. The window sum update and compare of one item overlap the root
// work of the next. The window starts as WINDOW zeros after reset, with no
// clearing pass: a fill flag masks unwritten entries. The threshold may only be
// written while no sample is in flight.
module accel_magnitude_average_threshold #(
  parameter int unsigned WINDOW = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // threshold register
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // magnitude[15:0], window_total[36:16],
                                      // direction[38:37], zero[39]
);

  logic [amat_pkg::THR_W-1:0] thr_q;

  logic                       sq_valid, sq_ready;
  logic [amat_pkg::MAG_W-1:0] sq_mag;
  logic                       win_valid, win_ready;
  amat_pkg::result_t          win_res;
  amat_pkg::result_t          out_q;
  logic                       out_valid_q;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= amat_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // magnitude unit
  amat_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .x_i         (s_axis_tdata[15:0]),
    .y_i         (s_axis_tdata[31:16]),
    .z_i         (s_axis_tdata[47:32]),
    .out_valid_o (sq_valid),
    .out_ready_i (sq_ready),
    .mag_o       (sq_mag)
  );

  // window sum and compare
  amat_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thr_i       (thr_q),
    .in_valid_i  (sq_valid),
    .in_ready_o  (sq_ready),
    .mag_i       (sq_mag),
    .out_valid_o (win_valid),
    .out_ready_i (win_ready),
    .res_o       (win_res)
  );

  // output register
  assign win_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (win_ready) begin
      out_valid_q <= win_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_ready && win_valid) begin
      out_q <= win_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.direction, out_q.window_total, out_q.magnitude};

endmodule
